FILE: sv/ws2812_lane_serializer_assert.svh
// ---------------------------------------------------------------------------
// ws2812_lane_serializer_assert.svh
// Assertion macros for the WS2812 lane serialiser. The bodies are empty
// when the design goes through synthesis.
// ---------------------------------------------------------------------------
`ifndef WS2812_LANE_SERIALIZER_ASSERT_SVH
`define WS2812_LANE_SERIALIZER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define WLS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("wls: implication violated");
// next-cycle implication
`define WLS_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("wls: next-cycle implication violated");
`else
`define WLS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define WLS_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

FILE: sv/wls_pkg.sv
// ---------------------------------------------------------------------------
// wls_pkg
// Shared types, register indexes and the gamma table of the WS2812 lane
// serialiser.
// ---------------------------------------------------------------------------
package wls_pkg;

  localparam int PIN_W     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_BLOCKED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA_ENABLE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH          = 3'd5;

  // reset values of the registers
  localparam logic [7:0]  RST_BIT_PERIOD = 8'd20;
  localparam logic [7:0]  RST_ZERO_HIGH  = 8'd5;
  localparam logic [7:0]  RST_ONE_HIGH   = 8'd14;
  localparam logic [15:0] RST_LATCH      = 16'd800;

  typedef struct packed {
    logic        output_blocked;
    logic        gamma_enable;
    logic [7:0]  bit_period_cycles;
    logic [7:0]  zero_high_cycles;
    logic [7:0]  one_high_cycles;
    logic [15:0] latch_cycles;
  } cfg_t;

  typedef struct packed {
    logic [PIN_W-1:0] lane_pins;
    logic             byte_taken;
    logic             byte_rejected;
    logic             busy_res;
  } res_t;

  // gamma correction table
  localparam logic [7:0] GAMMA_ROM [256] = '{
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd1,
      8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
      8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
      8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
      8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,
      8'd5,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,
      8'd7,   8'd8,   8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd10,
      8'd10,  8'd10,  8'd11,  8'd11,  8'd11,  8'd12,  8'd12,  8'd13,
      8'd13,  8'd13,  8'd14,  8'd14,  8'd15,  8'd15,  8'd16,  8'd16,
      8'd17,  8'd17,  8'd18,  8'd18,  8'd19,  8'd19,  8'd20,  8'd20,
      8'd21,  8'd21,  8'd22,  8'd22,  8'd23,  8'd24,  8'd24,  8'd25,
      8'd25,  8'd26,  8'd27,  8'd27,  8'd28,  8'd29,  8'd29,  8'd30,
      8'd31,  8'd32,  8'd32,  8'd33,  8'd34,  8'd35,  8'd35,  8'd36,
      8'd37,  8'd38,  8'd39,  8'd39,  8'd40,  8'd41,  8'd42,  8'd43,
      8'd44,  8'd45,  8'd46,  8'd47,  8'd48,  8'd49,  8'd50,  8'd50,
      8'd51,  8'd52,  8'd54,  8'd55,  8'd56,  8'd57,  8'd58,  8'd59,
      8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd66,  8'd67,  8'd68,
      8'd69,  8'd70,  8'd72,  8'd73,  8'd74,  8'd75,  8'd77,  8'd78,
      8'd79,  8'd81,  8'd82,  8'd83,  8'd85,  8'd86,  8'd87,  8'd89,
      8'd90,  8'd92,  8'd93,  8'd95,  8'd96,  8'd98,  8'd99,  8'd101,
      8'd102, 8'd104, 8'd105, 8'd107, 8'd109, 8'd110, 8'd112, 8'd114,
      8'd115, 8'd117, 8'd119, 8'd120, 8'd122, 8'd124, 8'd126, 8'd127,
      8'd129, 8'd131, 8'd133, 8'd135, 8'd137, 8'd138, 8'd140, 8'd142,
      8'd144, 8'd146, 8'd148, 8'd150, 8'd152, 8'd154, 8'd156, 8'd158,
      8'd160, 8'd162, 8'd164, 8'd167, 8'd169, 8'd171, 8'd173, 8'd175,
      8'd177, 8'd180, 8'd182, 8'd184, 8'd186, 8'd189, 8'd191, 8'd193,
      8'd196, 8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213,
      8'd215, 8'd218, 8'd220, 8'd223, 8'd225, 8'd228, 8'd231, 8'd233,
      8'd236, 8'd239, 8'd241, 8'd244, 8'd247, 8'd249, 8'd252, 8'd255
  };

endpackage

FILE: sv/ws2812_lane_serializer.sv
// ---------------------------------------------------------------------------
// ws2812_lane_serializer
// Four-lane WS2812 pulse serialiser: each item is one waveform tick that may
// offer a colour byte; each item yields one result with the pin levels.
// ---------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------------
//  in      | in_valid / in_stall | opcode, color_byte, lane_index, frame_end
//  out     | out_valid/out_stall | lane_pins, byte_taken, byte_rejected, busy_res
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One item per cycle while in_stall is low: the tick's result is formed from
//  the timing state and registered in the output stage, and the state steps in
//  the same edge. The result is shown in the cycle after acceptance.
//  in_stall is raised only while a result sits in the output stage and
//  out_stall holds it; the timing state does not move while stalled.
//  Synchronous active-high reset loads the register defaults and idles.
// ---------------------------------------------------------------------------
`include "ws2812_lane_serializer_assert.svh"

module ws2812_lane_serializer #(
  parameter int LANE_COUNT = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  // item input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           opcode,
  input  logic [7:0]                     color_byte,
  input  logic [1:0]                     lane_index,
  input  logic                           frame_end,
  // result output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [wls_pkg::PIN_W-1:0]      lane_pins,
  output logic                           byte_taken,
  output logic                           byte_rejected,
  output logic                           busy_res,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wls_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import wls_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_q;
  logic accept;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  wls_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wls_pulse_engine #(
    .LANE_COUNT (LANE_COUNT)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .tick       (accept),
    .opcode     (opcode),
    .color_byte (color_byte),
    .lane_index (lane_index),
    .frame_end  (frame_end),
    .cfg        (cfg),
    .res        (res)
  );

  // output stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign lane_pins     = res_q.lane_pins;
  assign byte_taken    = res_q.byte_taken;
  assign byte_rejected = res_q.byte_rejected;
  assign busy_res      = res_q.busy_res;

  // checks
  `WLS_ASSERT_IMP(a_stall_only_when_full, clk, rst, in_stall, out_valid)
  `WLS_ASSERT_IMP(a_one_pin_at_most, clk, rst, out_valid, $onehot0(lane_pins))
  `WLS_ASSERT_IMP(a_taken_only_idle, clk, rst, out_valid && byte_taken, !busy_res && !byte_rejected)
  `WLS_ASSERT_IMP(a_pins_need_busy, clk, rst, out_valid && lane_pins != '0, busy_res)
  `WLS_ASSERT_NXT(a_taken_then_busy, clk, rst, accept && res.byte_taken, res.busy_res)

endmodule

FILE: sv/wls_cfg_regs.sv
// ---------------------------------------------------------------------------
// wls_cfg_regs
// Configuration register file: six registers written through a simple
// valid/ready port that is always ready.
// ---------------------------------------------------------------------------
module wls_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wls_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wls_pkg::CFG_DAT_W-1:0]    cfg_data,
  output wls_pkg::cfg_t                    cfg
);
  import wls_pkg::*;

  cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.output_blocked    <= 1'b0;
      regs.gamma_enable      <= 1'b1;
      regs.bit_period_cycles <= RST_BIT_PERIOD;
      regs.zero_high_cycles  <= RST_ZERO_HIGH;
      regs.one_high_cycles   <= RST_ONE_HIGH;
      regs.latch_cycles      <= RST_LATCH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OUTPUT_BLOCKED: regs.output_blocked    <= cfg_data[0];
        REG_GAMMA_ENABLE:   regs.gamma_enable      <= cfg_data[0];
        REG_BIT_PERIOD:     regs.bit_period_cycles <= cfg_data[7:0];
        REG_ZERO_HIGH:      regs.zero_high_cycles  <= cfg_data[7:0];
        REG_ONE_HIGH:       regs.one_high_cycles   <= cfg_data[7:0];
        REG_LATCH:          regs.latch_cycles      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/wls_pulse_engine.sv
// ---------------------------------------------------------------------------
// wls_pulse_engine
// Bit timing state of the serialiser. Produces one tick's result from the
// current state and advances the state by one tick for each accepted item.
// ---------------------------------------------------------------------------
module wls_pulse_engine #(
  parameter int LANE_COUNT = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           tick,
  input  logic           opcode,
  input  logic [7:0]     color_byte,
  input  logic [1:0]     lane_index,
  input  logic           frame_end,
  input  wls_pkg::cfg_t  cfg,
  output wls_pkg::res_t  res
);
  import wls_pkg::*;

  logic [7:0]  shift_byte,    shift_byte_next;
  logic [3:0]  bits_left,     bits_left_next;
  logic [7:0]  cycle_in_bit,  cycle_in_bit_next;
  logic [1:0]  active_lane,   active_lane_next;
  logic        latch_pending, latch_pending_next;
  logic [15:0] latch_count,   latch_count_next;

  logic       sending;
  logic       busy;
  logic [7:0] high_cycles;
  logic       pin_high;
  logic       bit_done;

  assign sending     = (bits_left != 4'd0);
  assign busy        = sending || latch_pending;
  assign high_cycles = shift_byte[7] ? cfg.one_high_cycles : cfg.zero_high_cycles;
  assign pin_high    = sending && (cycle_in_bit < high_cycles);
  assign bit_done    = ({1'b0, cycle_in_bit} + 9'd1) >= {1'b0, cfg.bit_period_cycles};

  // result of this tick, from the state before the update
  always_comb begin
    res.lane_pins = '0;
    for (int i = 0; i < PIN_W; i++) begin
      if (i < LANE_COUNT && pin_high && active_lane == i[1:0]) begin
        res.lane_pins[i] = 1'b1;
      end
    end
    res.byte_taken    = opcode && !cfg.output_blocked && !busy;
    res.byte_rejected = opcode && cfg.output_blocked;
    res.busy_res      = busy;
  end

  // next state: advance the running bit or latch, then load an offered byte
  always_comb begin
    shift_byte_next    = shift_byte;
    bits_left_next     = bits_left;
    cycle_in_bit_next  = cycle_in_bit;
    active_lane_next   = active_lane;
    latch_pending_next = latch_pending;
    latch_count_next   = latch_count;

    if (sending) begin
      if (bit_done) begin
        cycle_in_bit_next = 8'd0;
        shift_byte_next   = {shift_byte[6:0], 1'b0};
        bits_left_next    = bits_left - 4'd1;
        // last bit with nothing left to wait for ends the frame at once
        if (bits_left == 4'd1 && latch_pending && latch_count == 16'd0) begin
          latch_pending_next = 1'b0;
        end
      end else begin
        cycle_in_bit_next = cycle_in_bit + 8'd1;
      end
    end else if (latch_pending) begin
      latch_count_next = latch_count - 16'd1;
      if (latch_count == 16'd1) begin
        latch_pending_next = 1'b0;
      end
    end

    if (res.byte_taken) begin
      shift_byte_next   = cfg.gamma_enable ? GAMMA_ROM[color_byte] : color_byte;
      bits_left_next    = 4'd8;
      cycle_in_bit_next = 8'd0;
      active_lane_next  = lane_index;
      if (frame_end) begin
        latch_pending_next = 1'b1;
        latch_count_next   = cfg.latch_cycles;
      end
    end
  end

  // state registers, one step per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_byte    <= '0;
      bits_left     <= '0;
      cycle_in_bit  <= '0;
      active_lane   <= '0;
      latch_pending <= 1'b0;
      latch_count   <= '0;
    end else if (tick) begin
      shift_byte    <= shift_byte_next;
      bits_left     <= bits_left_next;
      cycle_in_bit  <= cycle_in_bit_next;
      active_lane   <= active_lane_next;
      latch_pending <= latch_pending_next;
      latch_count   <= latch_count_next;
    end
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the four-lane WS2812 serialiser. A queue of ticks
// feeds a clocked driver; a tick-level model of the pulse timing predicts
// every result item, and a clocked monitor compares each one field by field.
// ---------------------------------------------------------------------------
module testbench;
  import wls_pkg::*;

  localparam int LANES       = 4;
  localparam int QUIET_LIMIT = 4000;

  typedef struct packed {
    logic       opcode;
    logic [7:0] colour;
    logic [1:0] lane;
    logic       fend;
  } tick_t;

  // timing state of the pulse generator
  typedef struct {
    logic [7:0]  shift;
    logic [3:0]  bits_left;
    logic [7:0]  cyc;
    logic [1:0]  lane;
    logic        latch_pending;
    logic [15:0] latch_count;
  } wave_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic                 opcode     = 1'b0;
  logic [7:0]           color_byte = 8'd0;
  logic [1:0]           lane_index = 2'd0;
  logic                 frame_end  = 1'b0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [PIN_W-1:0]     lane_pins;
  logic                 byte_taken;
  logic                 byte_rejected;
  logic                 busy_res;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_DAT_W-1:0] cfg_data   = '0;

  tick_t pending_ticks[$];
  res_t  tick_results_q[$];
  cfg_t  lane_cfg;
  wave_t wave;

  int tx_gap_pct  = 0;
  int rx_hold_pct = 0;
  bit squeeze_req = 1'b0;
  bit squeeze_done = 1'b0;
  int hold_left   = 0;
  int fail_count  = 0;
  int results_seen = 0;
  int quiet_cycles = 0;

  ws2812_lane_serializer #(.LANE_COUNT(LANES)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .color_byte(color_byte), .lane_index(lane_index),
    .frame_end(frame_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .lane_pins(lane_pins), .byte_taken(byte_taken),
    .byte_rejected(byte_rejected), .busy_res(busy_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // one tick of the pulse generator: result from the state at the start of
  // the tick, then the state steps
  function automatic res_t predict_tick(logic op, logic [7:0] colour, logic [1:0] lane,
                                        logic fend);
    res_t       r;
    logic [7:0] pulse_len;
    logic       sending;
    logic       was_busy;
    r        = '0;
    sending  = (wave.bits_left != 0);
    was_busy = sending || wave.latch_pending;
    if (sending) begin
      pulse_len = wave.shift[7] ? lane_cfg.one_high_cycles : lane_cfg.zero_high_cycles;
      if (wave.cyc < pulse_len && int'(wave.lane) < LANES)
        r.lane_pins = {{(PIN_W-1){1'b0}}, 1'b1} << wave.lane;
      if (int'(wave.cyc) + 1 >= int'(lane_cfg.bit_period_cycles)) begin
        wave.cyc       = '0;
        wave.shift     = wave.shift << 1;
        wave.bits_left = wave.bits_left - 1'b1;
        if (wave.bits_left == 0 && wave.latch_pending && wave.latch_count == 0)
          wave.latch_pending = 1'b0;
      end else begin
        wave.cyc = wave.cyc + 1'b1;
      end
    end else if (wave.latch_pending) begin
      wave.latch_count = wave.latch_count - 1'b1;
      if (wave.latch_count == 0)
        wave.latch_pending = 1'b0;
    end
    // byte offer
    if (op) begin
      if (lane_cfg.output_blocked) begin
        r.byte_rejected = 1'b1;
      end else if (!was_busy) begin
        r.byte_taken   = 1'b1;
        wave.shift     = lane_cfg.gamma_enable ? GAMMA_ROM[colour] : colour;
        wave.bits_left = 4'd8;
        wave.cyc       = '0;
        wave.lane      = lane;
        if (fend) begin
          wave.latch_pending = 1'b1;
          wave.latch_count   = lane_cfg.latch_cycles;
        end
      end
    end
    r.busy_res = was_busy;
    return r;
  endfunction

  task automatic note_mismatch(string what);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic push_offer(logic [7:0] colour, logic [1:0] lane, logic fend);
    pending_ticks.push_back('{opcode: 1'b1, colour: colour, lane: lane, fend: fend});
  endtask

  // plain ticks carry random content that the block must ignore
  task automatic push_ticks(int n);
    for (int i = 0; i < n; i++)
      pending_ticks.push_back('{opcode: 1'b0, colour: 8'($urandom),
                                lane: 2'($urandom), fend: 1'($urandom)});
  endtask

  // wait until every queued tick is in and every result is out
  task automatic wait_drained();
    @(negedge clk);
    while (pending_ticks.size() != 0 || in_valid || tick_results_q.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // called at a rising edge; leaves cfg_valid high for a following write
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_OUTPUT_BLOCKED: lane_cfg.output_blocked    = val[0];
      REG_GAMMA_ENABLE:   lane_cfg.gamma_enable      = val[0];
      REG_BIT_PERIOD:     lane_cfg.bit_period_cycles = val[7:0];
      REG_ZERO_HIGH:      lane_cfg.zero_high_cycles  = val[7:0];
      REG_ONE_HIGH:       lane_cfg.one_high_cycles   = val[7:0];
      REG_LATCH:          lane_cfg.latch_cycles      = val;
      default: ;
    endcase
  endtask

  // let the waveform run out, then load a full register set
  task automatic apply_settings(cfg_t s);
    wait_drained();
    while (wave.bits_left != 0 || wave.latch_pending) begin
      push_ticks(64);
      wait_drained();
    end
    cfg_write(REG_OUTPUT_BLOCKED, CFG_DAT_W'(s.output_blocked));
    cfg_write(REG_GAMMA_ENABLE,   CFG_DAT_W'(s.gamma_enable));
    cfg_write(REG_BIT_PERIOD,     CFG_DAT_W'(s.bit_period_cycles));
    cfg_write(REG_ZERO_HIGH,      CFG_DAT_W'(s.zero_high_cycles));
    cfg_write(REG_ONE_HIGH,       CFG_DAT_W'(s.one_high_cycles));
    cfg_write(REG_LATCH,          s.latch_cycles);
    cfg_valid <= 1'b0;
  endtask

  // driver: predicts on acceptance, then loads the next tick or idles
  always @(posedge clk) begin
    tick_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        tick_results_q.push_back(predict_tick(opcode, color_byte, lane_index, frame_end));
      if (!in_valid || !in_stall) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= tx_gap_pct) begin
          nxt = pending_ticks.pop_front();
          in_valid   <= 1'b1;
          opcode     <= nxt.opcode;
          color_byte <= nxt.colour;
          lane_index <= nxt.lane;
          frame_end  <= nxt.fend;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result item and drives the receiver stall
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (tick_results_q.size() == 0) begin
          note_mismatch($sformatf("result %0d arrived with none expected", results_seen));
        end else begin
          want = tick_results_q.pop_front();
          if (lane_pins !== want.lane_pins)
            note_mismatch($sformatf("result %0d lane_pins %b, expected %b",
                                    results_seen, lane_pins, want.lane_pins));
          if (byte_taken !== want.byte_taken)
            note_mismatch($sformatf("result %0d byte_taken %b, expected %b",
                                    results_seen, byte_taken, want.byte_taken));
          if (byte_rejected !== want.byte_rejected)
            note_mismatch($sformatf("result %0d byte_rejected %b, expected %b",
                                    results_seen, byte_rejected, want.byte_rejected));
          if (busy_res !== want.busy_res)
            note_mismatch($sformatf("result %0d busy_res %b, expected %b",
                                    results_seen, busy_res, want.busy_res));
        end
      end
      // long hold-off once, so the output stage fills and the input stalls
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        hold_left    = 199;
        out_stall   <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_hold_pct);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** ws2812_lane_serializer: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    cfg_t s;
    int   period;
    int   span;
    int   noise_at;
    logic fend;

    lane_cfg = '{output_blocked: 1'b0, gamma_enable: 1'b1,
                 bit_period_cycles: RST_BIT_PERIOD, zero_high_cycles: RST_ZERO_HIGH,
                 one_high_cycles: RST_ONE_HIGH, latch_cycles: RST_LATCH};
    wave = '{shift: '0, bits_left: '0, cyc: '0, lane: '0,
             latch_pending: 1'b0, latch_count: '0};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: full byte on the top lane, offer while busy ignored
    tx_gap_pct  = 15;
    rx_hold_pct = 15;
    push_offer(8'hFF, 2'd3, 1'b0);
    push_ticks(3);
    push_offer(8'h00, 2'd0, 1'b0);
    push_ticks(8 * 20 - 4);

    // shortest period, one-pulse longer than the bit, zero latch time
    apply_settings('{output_blocked: 1'b0, gamma_enable: 1'b0, bit_period_cycles: 8'd8,
                     zero_high_cycles: 8'd1, one_high_cycles: 8'd255, latch_cycles: 16'd0});
    push_offer(8'hA5, 2'd2, 1'b1);
    push_ticks(64);

    // output blocked: every offer refused
    apply_settings('{output_blocked: 1'b1, gamma_enable: 1'b1, bit_period_cycles: 8'd8,
                     zero_high_cycles: 8'd3, one_high_cycles: 8'd6, latch_cycles: 16'd5});
    push_offer(8'hFF, 2'd0, 1'b1);
    push_ticks(2);
    push_offer(8'h00, 2'd3, 1'b0);
    push_offer(8'h96, 2'd2, 1'b1);
    push_ticks(3);

    // blocking while a byte and its latch are in progress
    apply_settings('{output_blocked: 1'b0, gamma_enable: 1'b0, bit_period_cycles: 8'd8,
                     zero_high_cycles: 8'd2, one_high_cycles: 8'd6, latch_cycles: 16'd10});
    push_offer(8'hC3, 2'd1, 1'b1);
    push_ticks(20);
    wait_drained();
    cfg_write(REG_OUTPUT_BLOCKED, CFG_DAT_W'(1));
    cfg_valid <= 1'b0;
    push_offer(8'h3C, 2'd2, 1'b0);
    push_ticks(25);
    push_offer(8'hF0, 2'd0, 1'b1);
    push_ticks(28);

    // random part: well-formed byte streams with noise, fresh settings per segment
    for (int seg = 0; seg < 3; seg++) begin
      period = $urandom_range(8, 9);
      s.output_blocked    = ($urandom_range(7) == 0);
      s.gamma_enable      = $urandom_range(1);
      s.bit_period_cycles = 8'(period);
      s.zero_high_cycles  = ($urandom_range(5) == 0) ? 8'd255 : 8'($urandom_range(1, period + 2));
      s.one_high_cycles   = ($urandom_range(5) == 0) ? 8'd255 : 8'($urandom_range(1, period + 2));
      s.latch_cycles      = 16'($urandom_range(0, 8));
      apply_settings(s);
      tx_gap_pct  = (seg == 0) ? 36 : (seg == 1) ? 88 : 0;
      rx_hold_pct = (seg == 0) ? 88 : (seg == 1) ? 36 : 0;
      if (seg == 2)
        squeeze_req = 1'b1;
      for (int b = 0; b < 2; b++) begin
        fend = ($urandom_range(3) == 0);
        span = 8 * period + (fend ? int'(s.latch_cycles) : 0);
        // now and then an offer lands while busy; at the gap's end it is
        // an early attempt that the real offer repeats
        noise_at = ($urandom_range(4) == 0) ? $urandom_range(span - 1) : -1;
        push_offer(8'($urandom), 2'($urandom), fend);
        for (int i = 0; i < span; i++) begin
          if (i == noise_at)
            push_offer(8'($urandom), 2'($urandom), 1'($urandom));
          else
            push_ticks(1);
        end
        if ($urandom_range(4) == 0)
          push_ticks($urandom_range(1, 3));
      end
    end

    // wind down and give the verdict
    wait_drained();
    repeat (8) @(posedge clk);
    if (tick_results_q.size() != 0)
      note_mismatch($sformatf("%0d expected results never arrived", tick_results_q.size()));
    if (fail_count == 0)
      $display("** ws2812_lane_serializer: PASSED **");
    else
      $display("** ws2812_lane_serializer: FAILED **");
    $finish;
  end

endmodule

FILE: ws2812_lane_serializer.f
+incdir+sv
sv/wls_pkg.sv
sv/wls_cfg_regs.sv
sv/wls_pulse_engine.sv
sv/ws2812_lane_serializer.sv
sim/testbench.sv
